FILE: rtl/sst_pkg.sv
// Shared types and constants for the looping sine tone source.
// Holds field widths, register indexes, fixed-point constants and the
// configuration state encoding. No dependencies.
package sst_pkg;

    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned INDEX_W     = 16;
    localparam int unsigned PHASE_W     = 16;
    localparam int unsigned HZ_W        = 16;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned AMP_W       = 31;
    localparam int unsigned Q30_W       = 31;
    localparam int unsigned S17_W       = 18;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_TONE_HZ       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_PERCENT = 8'd1;

    localparam logic [HZ_W-1:0]  HZ_MIN      = 16'd20;
    localparam logic [HZ_W-1:0]  HZ_MAX      = 16'd20000;
    localparam logic [HZ_W-1:0]  HZ_DEFAULT  = 16'd440;
    localparam logic [7:0]       PCT_MIN     = 8'd1;
    localparam logic [7:0]       PCT_MAX     = 8'd100;
    localparam logic [PCT_W-1:0] PCT_DEFAULT = 7'd20;

    // floor(32767 * 65536 * pct / 100) = AMP_WHOLE * pct + floor(12 * pct / 100)
    localparam logic [31:0] AMP_WHOLE    = 32'd21474181;
    localparam logic [15:0] AMP_FRAC_MUL = 16'd492;
    localparam int unsigned AMP_FRAC_SH  = 12;

    localparam logic [Q30_W-1:0] Q30_ONE = 31'd1073741824;
    localparam logic [Q30_W-1:0] K1      = 31'd1686629713;
    localparam logic [Q30_W-1:0] K3      = 31'd693598668;
    localparam logic [Q30_W-1:0] K5      = 31'd85569306;
    localparam logic [Q30_W-1:0] K7      = 31'd5026995;
    localparam logic [Q30_W-1:0] K9      = 31'd172272;
    localparam logic [S17_W-1:0] S17_MAX = 18'd131072;

    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_GCD,
        CFG_DIV,
        CFG_LEN
    } cfg_state_t;

    typedef struct packed {
        logic                busy;
        logic [HZ_W-1:0]     eff_hz;
        logic [AMP_W-1:0]    amp;
        logic [INDEX_W-1:0]  loop_len;
    } cfg_status_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [INDEX_W-1:0] index;
        logic               last;
    } frame_t;

endpackage

FILE: rtl/seamless_loop_sine_tone.sv
// Top level of the looping stereo sine tone source.
// Instantiates sst_cfg, sst_phase and sst_sine; depends on sst_pkg.
//
// Usage:
//   Each transfer on the s_axis channel asks for one stereo frame; tdata[0]
//   set restarts the loop at frame zero before the frame is produced. Each
//   frame leaves on m_axis with both channels, its loop position and tlast
//   on the last frame of the loop.
//   The cfg channel writes tone_hz (index 0) and level_percent (index 1);
//   other indexes are ignored. cfg_ready is always high.
//   Throughput: one frame per cycle while the receiver keeps up and the
//   loop length unit is idle. A frame reaches m_axis through an
//   eleven-register pipeline (input register, quadrant fold, Q30 angle
//   divide and correction, six series products, amplitude product into the
//   output register). After reset and after each accepted register write the
//   loop length is recomputed by a binary gcd and a 16-step divide;
//   s_axis_tready stays low meanwhile. Reset clears phase and loop position.
//   When the receiver stalls, frames collect in the pipeline stages and
//   s_axis_tready falls only once every stage holds a frame.
module seamless_loop_sine_tone #(
    parameter int SAMPLE_RATE     = 44100,
    parameter int MAX_LOOP_CYCLES = 1000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sst_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [0] restart
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // left, right, frame_index
    output logic                            m_axis_tlast,   // loop_end
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sst_pkg::*;

    cfg_status_t         status;
    frame_t              frame;
    logic                sine_ready;
    logic                accept;
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  out_index;

    assign s_axis_tready = sine_ready && !status.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sst_cfg #(
        .SAMPLE_RATE     (SAMPLE_RATE),
        .MAX_LOOP_CYCLES (MAX_LOOP_CYCLES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status)
    );

    sst_phase #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .restart  (s_axis_tdata[0]),
        .eff_hz   (status.eff_hz),
        .loop_len (status.loop_len),
        .frame    (frame)
    );

    sst_sine #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid && !status.busy),
        .in_ready  (sine_ready),
        .frame     (frame),
        .amp       (status.amp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sample    (sample),
        .out_index (out_index),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_index, sample, sample};

endmodule

FILE: rtl/sst_cfg.sv
// Configuration registers and loop length unit for the sine tone source.
// Loop length comes from a binary gcd followed by a restoring divide.
// Depends on sst_pkg.
module sst_cfg #(
    parameter int SAMPLE_RATE     = 44100,
    parameter int MAX_LOOP_CYCLES = 1000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sst_pkg::cfg_status_t            status
);
    import sst_pkg::*;

    localparam int MAX_W = $clog2(MAX_LOOP_CYCLES + 1);
    localparam int CAP_W = HZ_W + MAX_W;
    localparam logic [HZ_W-1:0]    RATE       = 16'(SAMPLE_RATE);
    localparam logic [INDEX_W-1:0] RATE_TENTH = 16'(SAMPLE_RATE / 10);
    localparam logic [MAX_W-1:0]   MAX_CYC    = MAX_W'(MAX_LOOP_CYCLES);

    cfg_state_t          st_reg, st_next;
    logic [HZ_W-1:0]     eff_hz_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [AMP_W-1:0]    amp_reg;
    logic [HZ_W-1:0]     a_reg, a_next;
    logic [HZ_W-1:0]     b_reg, b_next;
    logic [3:0]          sh_reg, sh_next;
    logic [HZ_W-1:0]     rem_reg, rem_next;
    logic [INDEX_W-1:0]  quo_reg, quo_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [INDEX_W-1:0]  len_reg, len_next;

    logic                write_hit;
    logic [HZ_W-1:0]     data_hz;
    logic [HZ_W-1:0]     new_hz;
    logic [PCT_W-1:0]    new_pct;
    logic [HZ_W:0]       rem_try;
    logic [HZ_W-1:0]     g_full;
    logic [CAP_W-1:0]    cap;
    logic [31:0]         amp_whole;
    logic [15:0]         amp_frac;

    assign cfg_ready = 1'b1;
    assign write_hit = cfg_valid && (cfg_index == REG_TONE_HZ || cfg_index == REG_LEVEL_PERCENT);

    always_comb
    begin
        data_hz = cfg_data[HZ_W-1:0];
        if (data_hz < HZ_MIN || data_hz > HZ_MAX)
            data_hz = HZ_DEFAULT;
        new_hz = (cfg_index == REG_TONE_HZ) ? data_hz : eff_hz_reg;
        if (cfg_data[7:0] < PCT_MIN)
            new_pct = PCT_W'(PCT_MIN);
        else if (cfg_data[7:0] > PCT_MAX)
            new_pct = PCT_W'(PCT_MAX);
        else
            new_pct = cfg_data[PCT_W-1:0];
    end

    always_comb
    begin
        st_next  = st_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        rem_try  = {rem_reg, RATE[cnt_reg]};
        g_full   = a_reg << sh_reg;
        cap      = CAP_W'(a_reg) * CAP_W'(MAX_CYC);
        case (st_reg)
            CFG_IDLE:
            begin
            end
            CFG_GCD:
            begin
                if (a_reg == b_reg)
                begin
                    a_next   = g_full;
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = 4'd15;
                    st_next  = CFG_DIV;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next  = a_reg >> 1;
                    b_next  = b_reg >> 1;
                    sh_next = sh_reg + 4'd1;
                end
                else if (!a_reg[0])
                    a_next = a_reg >> 1;
                else if (!b_reg[0])
                    b_next = b_reg >> 1;
                else if (a_reg > b_reg)
                    a_next = a_reg - b_reg;
                else
                    b_next = b_reg - a_reg;
            end
            CFG_DIV:
            begin
                if (rem_try >= {1'b0, a_reg})
                begin
                    rem_next = HZ_W'(rem_try - {1'b0, a_reg});
                    quo_next = {quo_reg[INDEX_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_try[HZ_W-1:0];
                    quo_next = {quo_reg[INDEX_W-2:0], 1'b0};
                end
                if (cnt_reg == 4'd0)
                    st_next = CFG_LEN;
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            CFG_LEN:
            begin
                len_next = (CAP_W'(eff_hz_reg) <= cap) ? quo_reg : RATE_TENTH;
                st_next  = CFG_IDLE;
            end
            default:
                st_next = CFG_IDLE;
        endcase
        if (write_hit)
        begin
            st_next = CFG_GCD;
            a_next  = RATE;
            b_next  = new_hz;
            sh_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= CFG_GCD;
            eff_hz_reg <= HZ_DEFAULT;
            pct_reg    <= PCT_DEFAULT;
            a_reg      <= RATE;
            b_reg      <= HZ_DEFAULT;
            sh_reg     <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            cnt_reg    <= '0;
            len_reg    <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_next;
            len_reg <= len_next;
            if (cfg_valid && cfg_index == REG_TONE_HZ)
                eff_hz_reg <= data_hz;
            if (cfg_valid && cfg_index == REG_LEVEL_PERCENT)
                pct_reg <= new_pct;
        end
    end

    assign amp_whole = AMP_WHOLE * 32'(pct_reg);
    assign amp_frac  = AMP_FRAC_MUL * 16'(pct_reg);

    always_ff @(posedge clk)
    begin
        amp_reg <= AMP_W'(amp_whole + 32'(amp_frac[15:AMP_FRAC_SH]));
    end

    assign status.busy     = (st_reg != CFG_IDLE);
    assign status.eff_hz   = eff_hz_reg;
    assign status.amp      = amp_reg;
    assign status.loop_len = len_reg;

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        write_hit |=> status.busy)
        else $error("loop length unit not started by register write");

    a_len_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> len_reg != '0)
        else $error("idle with zero loop length");

endmodule

FILE: rtl/sst_phase.sv
// Loop position and phase accumulator for the sine tone source.
// Builds the frame descriptor for each accepted transfer. Depends on sst_pkg.
module sst_phase #(
    parameter int SAMPLE_RATE = 44100
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        restart,
    input  logic [sst_pkg::HZ_W-1:0]    eff_hz,
    input  logic [sst_pkg::INDEX_W-1:0] loop_len,
    output sst_pkg::frame_t             frame
);
    import sst_pkg::*;

    localparam logic [17:0] RATE1 = 18'(SAMPLE_RATE);
    localparam logic [17:0] RATE2 = 18'(2 * SAMPLE_RATE);
    localparam logic [17:0] RATE3 = 18'(3 * SAMPLE_RATE);

    logic [PHASE_W-1:0] phase_reg;
    logic [INDEX_W-1:0] pos_reg;
    logic               wrap;
    logic [PHASE_W-1:0] cur_phase;
    logic [INDEX_W-1:0] cur_pos;
    logic               last;
    logic [17:0]        sum;
    logic [17:0]        sum_mod;

    always_comb
    begin
        wrap      = restart || (pos_reg >= loop_len);
        cur_phase = wrap ? '0 : phase_reg;
        cur_pos   = wrap ? '0 : pos_reg;
        last      = ({1'b0, cur_pos} + 17'd1) >= {1'b0, loop_len};
        sum       = 18'(cur_phase) + 18'(eff_hz);
        if (sum >= RATE3)
            sum_mod = sum - RATE3;
        else if (sum >= RATE2)
            sum_mod = sum - RATE2;
        else if (sum >= RATE1)
            sum_mod = sum - RATE1;
        else
            sum_mod = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                phase_reg <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                phase_reg <= sum_mod[PHASE_W-1:0];
                pos_reg   <= cur_pos + 16'd1;
            end
        end
    end

    assign frame.phase = cur_phase;
    assign frame.index = cur_pos;
    assign frame.last  = last;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        18'(phase_reg) < RATE1)
        else $error("phase accumulator out of range");

endmodule

FILE: rtl/sst_sine.sv
// Sample pipeline for the sine tone source: quadrant fold, Q30 angle,
// Horner series, amplitude scaling and output register. Depends on sst_pkg.
module sst_sine #(
    parameter int SAMPLE_RATE = 44100
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sst_pkg::frame_t              frame,
    input  logic [sst_pkg::AMP_W-1:0]    amp,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sst_pkg::SAMPLE_W-1:0] sample,
    output logic [sst_pkg::INDEX_W-1:0]  out_index,
    output logic                         out_last
);
    import sst_pkg::*;

    localparam int NST     = 11;
    localparam int RECIP_W = 34;
    localparam logic [15:0]        RATE  = 16'(SAMPLE_RATE);
    localparam logic [17:0]        RATE1 = 18'(SAMPLE_RATE);
    localparam logic [17:0]        RATE2 = 18'(2 * SAMPLE_RATE);
    localparam logic [17:0]        RATE3 = 18'(3 * SAMPLE_RATE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 46) / 64'(SAMPLE_RATE));

    logic [NST-1:0]      v_reg;
    logic [NST:0]        rdy;
    logic [INDEX_W-1:0]  idx_reg [NST];
    logic                last_reg [NST];
    logic                neg_reg [1:NST-1];

    logic [PHASE_W-1:0]  phase0_reg;
    logic [15:0]         u1_reg;
    logic [15:0]         u2_reg;
    logic [Q30_W-1:0]    qe2_reg;
    logic [Q30_W-1:0]    z_reg [3:8];
    logic [Q30_W-1:0]    z2_reg [4:7];
    logic [Q30_W-1:0]    t7_reg;
    logic [Q30_W-1:0]    t5_reg;
    logic [Q30_W-1:0]    t3_reg;
    logic [Q30_W-1:0]    t1_reg;
    logic [S17_W-1:0]    s17_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic [17:0]         p4;
    logic [1:0]          quad;
    logic [17:0]         rm;
    logic [15:0]         u_c;
    logic [49:0]         qe_prod;
    logic [46:0]         corr;
    logic [46:0]         rem;
    logic [Q30_W-1:0]    z_c;
    logic [61:0]         zz_prod;
    logic [61:0]         t7_prod;
    logic [61:0]         t5_prod;
    logic [61:0]         t3_prod;
    logic [61:0]         t1_prod;
    logic [61:0]         s_prod;
    logic [S17_W-1:0]    s17_c;
    logic [48:0]         m_prod;
    logic [SAMPLE_W-1:0] mag;

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_comb
    begin
        p4 = {phase0_reg, 2'b00};
        if (p4 >= RATE3)
        begin
            quad = 2'd3;
            rm   = p4 - RATE3;
        end
        else if (p4 >= RATE2)
        begin
            quad = 2'd2;
            rm   = p4 - RATE2;
        end
        else if (p4 >= RATE1)
        begin
            quad = 2'd1;
            rm   = p4 - RATE1;
        end
        else
        begin
            quad = 2'd0;
            rm   = p4;
        end
        u_c = quad[0] ? (RATE - rm[15:0]) : rm[15:0];

        qe_prod = 50'(u1_reg) * 50'(RECIP);

        corr = 47'(qe2_reg) * 47'(RATE);
        rem  = {1'b0, u2_reg, 30'b0} - corr;
        z_c  = (rem >= 47'(RATE)) ? (qe2_reg + 31'd1) : qe2_reg;
        if (z_c > Q30_ONE)
            z_c = Q30_ONE;

        zz_prod = 62'(z_reg[3]) * 62'(z_reg[3]);
        t7_prod = 62'(z2_reg[4]) * 62'(K9);
        t5_prod = 62'(z2_reg[5]) * 62'(t7_reg);
        t3_prod = 62'(z2_reg[6]) * 62'(t5_reg);
        t1_prod = 62'(z2_reg[7]) * 62'(t3_reg);
        s_prod  = 62'(z_reg[8]) * 62'(t1_reg);
        s17_c   = s_prod[60:43];
        if (s17_c > S17_MAX)
            s17_c = S17_MAX;

        m_prod = 49'(amp) * 49'(s17_reg);
        mag    = m_prod[48:33];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            phase0_reg  <= frame.phase;
            idx_reg[0]  <= frame.index;
            last_reg[0] <= frame.last;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (rdy[k])
            begin
                idx_reg[k]  <= idx_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
        if (rdy[1])
            neg_reg[1] <= quad[1];
        for (int k = 2; k < NST; k++)
        begin
            if (rdy[k])
                neg_reg[k] <= neg_reg[k-1];
        end
        if (rdy[1])
            u1_reg <= u_c;
        if (rdy[2])
        begin
            u2_reg  <= u1_reg;
            qe2_reg <= qe_prod[46:16];
        end
        if (rdy[3])
            z_reg[3] <= z_c;
        for (int k = 4; k <= 8; k++)
        begin
            if (rdy[k])
                z_reg[k] <= z_reg[k-1];
        end
        if (rdy[4])
            z2_reg[4] <= zz_prod[60:30];
        for (int k = 5; k <= 7; k++)
        begin
            if (rdy[k])
                z2_reg[k] <= z2_reg[k-1];
        end
        if (rdy[5])
            t7_reg <= K7 - t7_prod[60:30];
        if (rdy[6])
            t5_reg <= K5 - t5_prod[60:30];
        if (rdy[7])
            t3_reg <= K3 - t3_prod[60:30];
        if (rdy[8])
            t1_reg <= K1 - t1_prod[60:30];
        if (rdy[9])
            s17_reg <= s17_c;
        if (rdy[10])
            sample_reg <= neg_reg[9] ? (16'd0 - mag) : mag;
    end

    assign out_valid = v_reg[NST-1];
    assign sample    = sample_reg;
    assign out_index = idx_reg[NST-1];
    assign out_last  = last_reg[NST-1];

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_reg != 16'h8000)
        else $error("sample outside symmetric range");

endmodule
